### design/mcfr_pkg.sv
// mcfr_pkg: shared types and codes for the motor command frame receiver
// no dependencies; imported by the top level, the reply checker and the testbench

package mcfr_pkg;

    // link phase of the frame receiver
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RECV = 2'd1,
        PH_EOF  = 2'd2
    } t_phase;

    // bridge mode, as reported on drive_mode
    typedef enum logic [1:0] {
        MODE_COAST = 2'd0,
        MODE_FWD   = 2'd1,
        MODE_REV   = 2'd2,
        MODE_BRAKE = 2'd3
    } t_mode;

    // receive event kinds
    localparam logic [2:0] EV_DATA     = 3'd0;
    localparam logic [2:0] EV_MATCH    = 3'd1;
    localparam logic [2:0] EV_MISMATCH = 3'd2;
    localparam logic [2:0] EV_EOF      = 3'd3;
    localparam logic [2:0] EV_IGNORE   = 3'd4;
    localparam logic [2:0] EV_ERROR    = 3'd5;

    // error codes carried in the second byte of an error frame
    localparam logic [7:0] ERR_MISSING_DATA = 8'd1;
    localparam logic [7:0] ERR_BAD_DATA     = 8'd2;
    localparam logic [7:0] ERR_MISSING_EOF  = 8'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_NODE_ADDRESS = 3'd0;
    localparam logic [2:0] CFG_CODE_FORWARD = 3'd1;
    localparam logic [2:0] CFG_CODE_REVERSE = 3'd2;
    localparam logic [2:0] CFG_CODE_COAST   = 3'd3;
    localparam logic [2:0] CFG_CODE_BRAKE   = 3'd4;
    localparam logic [2:0] CFG_CODE_STATUS  = 3'd5;

    // speed must lie below this limit (and above zero)
    localparam logic [7:0] SPEED_LIMIT = 8'd100;

    // reply frame lengths
    localparam logic [2:0] LEN_NONE   = 3'd0;
    localparam logic [2:0] LEN_ERROR  = 3'd2;
    localparam logic [2:0] LEN_STATUS = 3'd4;

endpackage

### design/mcfr_evt_if.sv
// mcfr_evt_if: valid/ready channel for classified receive events
// depends on nothing but the signals it carries

interface mcfr_evt_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_kind;
    logic [7:0] rx_byte;

    modport source (output valid, output event_kind, output rx_byte, input ready);
    modport sink   (input valid, input event_kind, input rx_byte, output ready);
endinterface

### design/mcfr_reply_if.sv
// mcfr_reply_if: valid/ready channel for reply frame words
// depends on nothing but the signals it carries

interface mcfr_reply_if;
    logic       valid;
    logic       ready;
    logic [7:0] reply_byte;
    logic       reply_last;
    logic [1:0] drive_mode;
    logic [6:0] drive_duty;

    modport source (output valid, output reply_byte, output reply_last,
                    output drive_mode, output drive_duty, input ready);
    modport sink   (input valid, input reply_byte, input reply_last,
                    input drive_mode, input drive_duty, output ready);
endinterface

### design/motor_command_frame_receiver.sv
// motor_command_frame_receiver: frame decoder and reply generator for an h-bridge node
// depends on mcfr_pkg, mcfr_evt_if and mcfr_reply_if

// Takes one classified receive event per word on i_evt. After an address match
// it collects command, speed and check bytes, then expects end of frame; a good
// motor command updates the bridge mode and duty and, like a status query, is
// answered with a 4-word status frame (node address, check byte, code of the
// current mode, speed), a failed one with a 2-word error frame (node address,
// error code). Each event is decoded in the cycle it is accepted and its reply
// is loaded into a 4-word reply shift register, which then drains one word per
// cycle on o_reply while o_reply.ready is high. An event that causes no reply
// leaves the input ready; one that causes a reply holds the input until its
// last reply word leaves, and a new event is taken in the same cycle that word
// leaves. Configuration writes on i_cfg_* take effect at the next clock edge
// and are expected only while idle.

module motor_command_frame_receiver
    import mcfr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [7:0]   i_cfg_data,
    mcfr_evt_if.sink     i_evt,
    mcfr_reply_if.source o_reply
);

    // configuration registers
    logic [7:0] r_node_address;
    logic [7:0] r_code_forward;
    logic [7:0] r_code_reverse;
    logic [7:0] r_code_coast;
    logic [7:0] r_code_brake;
    logic [7:0] r_code_status;

    // link state
    t_phase     r_phase, n_phase;
    logic [1:0] r_taken, n_taken;
    logic [7:0] r_held_cmd, n_held_cmd;
    logic [7:0] r_held_speed, n_held_speed;
    logic [7:0] r_held_check, n_held_check;
    t_mode      r_mode, n_mode;
    logic [7:0] r_speed, n_speed;

    // reply shift register: word 0 is always the one on offer
    logic [7:0] r_frame [4];
    logic [7:0] n_frame [4];
    logic [2:0] r_remain;
    logic [2:0] n_len;
    t_mode      r_frame_mode;
    logic [6:0] r_frame_duty;

    logic       evt_acc;
    logic       reply_take;
    logic       known_cmd;
    logic       frame_ok;
    logic [7:0] err_code;
    logic       send_status;
    logic [7:0] mode_code;
    logic [6:0] n_duty;

    // handshakes: a new event enters once the reply register is empty or is
    // giving up its last word in this cycle
    assign reply_take  = o_reply.valid && o_reply.ready;
    assign i_evt.ready = (r_remain == LEN_NONE) || ((r_remain == 3'd1) && o_reply.ready);
    assign evt_acc     = i_evt.valid && i_evt.ready;

    // frame checks on the held bytes
    assign known_cmd = (r_held_cmd == r_code_forward) || (r_held_cmd == r_code_reverse) ||
                       (r_held_cmd == r_code_coast)   || (r_held_cmd == r_code_brake);
    assign frame_ok  = (r_held_speed != 8'd0) && (r_held_speed < SPEED_LIMIT) &&
                       (r_held_check == (r_held_cmd ^ r_held_speed));

    // next link phase
    always_comb begin
        n_phase = r_phase;
        if (evt_acc) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_evt.event_kind == EV_MATCH) begin
                        n_phase = PH_RECV;
                    end
                end
                PH_RECV: begin
                    if (i_evt.event_kind != EV_DATA) begin
                        n_phase = PH_IDLE;
                    end else if (r_taken == 2'd2) begin
                        n_phase = PH_EOF;
                    end
                end
                PH_EOF:  n_phase = PH_IDLE;
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // held bytes, motor state and reply selection
    always_comb begin
        n_taken      = r_taken;
        n_held_cmd   = r_held_cmd;
        n_held_speed = r_held_speed;
        n_held_check = r_held_check;
        n_mode       = r_mode;
        n_speed      = r_speed;
        n_len        = LEN_NONE;
        err_code     = ERR_BAD_DATA;
        send_status  = 1'b0;
        if (evt_acc) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_evt.event_kind == EV_MATCH) begin
                        n_taken      = 2'd0;
                        n_held_cmd   = 8'd0;
                        n_held_speed = 8'd0;
                        n_held_check = 8'd0;
                    end
                end
                PH_RECV: begin
                    if (i_evt.event_kind != EV_DATA) begin
                        n_len    = LEN_ERROR;
                        err_code = ERR_MISSING_DATA;
                    end else begin
                        case (r_taken)
                            2'd0: n_held_cmd   = i_evt.rx_byte;
                            2'd1: n_held_speed = i_evt.rx_byte;
                            default: n_held_check = i_evt.rx_byte;
                        endcase
                        n_taken = r_taken + 2'd1;
                    end
                end
                PH_EOF: begin
                    if (i_evt.event_kind != EV_EOF) begin
                        n_len    = LEN_ERROR;
                        err_code = ERR_MISSING_EOF;
                    end else if (known_cmd) begin
                        if (!frame_ok) begin
                            n_len    = LEN_ERROR;
                            err_code = ERR_BAD_DATA;
                        end else begin
                            n_len       = LEN_STATUS;
                            send_status = 1'b1;
                            // first match wins: forward, reverse, coast, brake
                            if (r_held_cmd == r_code_forward) begin
                                n_mode  = MODE_FWD;
                                n_speed = r_held_speed;
                            end else if (r_held_cmd == r_code_reverse) begin
                                n_mode  = MODE_REV;
                                n_speed = r_held_speed;
                            end else if (r_held_cmd == r_code_coast) begin
                                n_mode  = MODE_COAST;
                                n_speed = 8'd1;
                            end else begin
                                n_mode  = MODE_BRAKE;
                                n_speed = r_held_speed;
                            end
                        end
                    end else if (r_held_cmd == r_code_status) begin
                        n_len       = LEN_STATUS;
                        send_status = 1'b1;
                    end else begin
                        n_len    = LEN_ERROR;
                        err_code = ERR_BAD_DATA;
                    end
                end
                default: begin
                    // unused phase: back to idle with the frame cleared
                    n_taken      = 2'd0;
                    n_held_cmd   = 8'd0;
                    n_held_speed = 8'd0;
                    n_held_check = 8'd0;
                end
            endcase
            // every reply clears the frame
            if (n_len != LEN_NONE) begin
                n_taken      = 2'd0;
                n_held_cmd   = 8'd0;
                n_held_speed = 8'd0;
                n_held_check = 8'd0;
            end
        end
    end

    // reply words, built from the mode after this event
    always_comb begin
        unique case (n_mode)
            MODE_FWD:   mode_code = r_code_forward;
            MODE_REV:   mode_code = r_code_reverse;
            MODE_BRAKE: mode_code = r_code_brake;
            default:    mode_code = r_code_coast;
        endcase
        n_duty = ((n_mode == MODE_FWD) || (n_mode == MODE_REV)) ? n_speed[6:0] : 7'd0;
        n_frame[0] = r_node_address;
        if (send_status) begin
            n_frame[1] = r_held_check;
            n_frame[2] = mode_code;
            n_frame[3] = n_speed;
        end else begin
            n_frame[1] = err_code;
            n_frame[2] = 8'd0;
            n_frame[3] = 8'd0;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_address <= 8'd0;
            r_code_forward <= 8'd1;
            r_code_reverse <= 8'd2;
            r_code_coast   <= 8'd3;
            r_code_brake   <= 8'd4;
            r_code_status  <= 8'd5;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NODE_ADDRESS: r_node_address <= i_cfg_data;
                CFG_CODE_FORWARD: r_code_forward <= i_cfg_data;
                CFG_CODE_REVERSE: r_code_reverse <= i_cfg_data;
                CFG_CODE_COAST:   r_code_coast   <= i_cfg_data;
                CFG_CODE_BRAKE:   r_code_brake   <= i_cfg_data;
                CFG_CODE_STATUS:  r_code_status  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // link and motor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_taken      <= 2'd0;
            r_held_cmd   <= 8'd0;
            r_held_speed <= 8'd0;
            r_held_check <= 8'd0;
            r_mode       <= MODE_COAST;
            r_speed      <= 8'd1;
        end else begin
            r_phase      <= n_phase;
            r_taken      <= n_taken;
            r_held_cmd   <= n_held_cmd;
            r_held_speed <= n_held_speed;
            r_held_check <= n_held_check;
            r_mode       <= n_mode;
            r_speed      <= n_speed;
        end
    end

    // reply word count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remain <= LEN_NONE;
        end else if (evt_acc) begin
            r_remain <= n_len;
        end else if (reply_take) begin
            r_remain <= r_remain - 3'd1;
        end
    end

    // reply payload: load on a new reply, shift on each word taken
    always_ff @(posedge i_clk) begin
        if (evt_acc && (n_len != LEN_NONE)) begin
            r_frame      <= n_frame;
            r_frame_mode <= n_mode;
            r_frame_duty <= n_duty;
        end else if (reply_take) begin
            r_frame[0] <= r_frame[1];
            r_frame[1] <= r_frame[2];
            r_frame[2] <= r_frame[3];
        end
    end

    assign o_reply.valid      = (r_remain != LEN_NONE);
    assign o_reply.reply_byte = r_frame[0];
    assign o_reply.reply_last = (r_remain == 3'd1);
    assign o_reply.drive_mode = r_frame_mode;
    assign o_reply.drive_duty = r_frame_duty;

    // the end-of-frame phase is reached only with all three bytes held
    a_eof_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_EOF) |-> (r_taken == 2'd3))
        else $error("end-of-frame phase without three held bytes");

    // a reply never holds more than a status frame
    a_remain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_remain <= LEN_STATUS))
        else $error("reply word count out of range");

    // an event that raises a reply is offered on the next cycle with its full length
    a_reply_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (evt_acc && (n_len != LEN_NONE)) |=> (o_reply.valid && (r_remain == $past(n_len))))
        else $error("reply not loaded after event");

    // duty is zero unless the bridge drives forward or reverse
    a_duty_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_reply.valid && (r_frame_mode == MODE_COAST || r_frame_mode == MODE_BRAKE))
            |-> (o_reply.drive_duty == 7'd0))
        else $error("duty reported while coasting or braking");

endmodule

### dv/mcfr_reply_checker.sv
`timescale 1ns / 100ps
// mcfr_reply_checker: watches the event, reply and register ports of the frame receiver,
// predicts every reply word and compares it with what the block sends; uses mcfr_pkg

module mcfr_reply_checker
    import mcfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_evt_valid,
    input  logic       i_evt_ready,
    input  logic [2:0] i_evt_kind,
    input  logic [7:0] i_evt_byte,
    input  logic       i_reply_valid,
    input  logic       i_reply_ready,
    input  logic [7:0] i_reply_byte,
    input  logic       i_reply_last,
    input  logic [1:0] i_drive_mode,
    input  logic [6:0] i_drive_duty,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [7:0] reply_byte;
        logic       reply_last;
        logic [1:0] drive_mode;
        logic [6:0] drive_duty;
    } t_reply_word;

    t_reply_word owed_replies[$];

    // register copies
    logic [7:0] node_addr, cd_fwd, cd_rev, cd_coast, cd_brake, cd_status;

    // frame and bridge state
    t_phase     phase;
    logic [1:0] taken;
    logic [7:0] held_cmd, held_spd, held_chk;
    t_mode      bridge_mode;
    logic [7:0] bridge_speed;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [7:0] current_mode_code();
        case (bridge_mode)
            MODE_FWD:   return cd_fwd;
            MODE_REV:   return cd_rev;
            MODE_BRAKE: return cd_brake;
            default:    return cd_coast;
        endcase
    endfunction

    function automatic void drop_frame();
        taken    = 2'd0;
        held_cmd = 8'd0;
        held_spd = 8'd0;
        held_chk = 8'd0;
    endfunction

    // queue a reply of len words, all tagged with the bridge state as it stands now
    function automatic void owe_reply(input logic [7:0] w0, input logic [7:0] w1,
                                      input logic [7:0] w2, input logic [7:0] w3,
                                      input int len);
        logic [7:0]  words [4];
        t_reply_word w;
        words = '{w0, w1, w2, w3};
        for (int k = 0; k < len; k++) begin
            w.reply_byte = words[k[1:0]];
            w.reply_last = (k == len - 1);
            w.drive_mode = bridge_mode;
            w.drive_duty = (bridge_mode == MODE_FWD || bridge_mode == MODE_REV) ?
                           bridge_speed[6:0] : 7'd0;
            owed_replies.push_back(w);
        end
        drop_frame();
    endfunction

    function automatic void owe_error(input logic [7:0] code);
        owe_reply(node_addr, code, 8'd0, 8'd0, int'(LEN_ERROR));
    endfunction

    function automatic void owe_status();
        owe_reply(node_addr, held_chk, current_mode_code(), bridge_speed, int'(LEN_STATUS));
    endfunction

    function automatic void decode_event(input logic [2:0] kind, input logic [7:0] data);
        logic [7:0] cmd;
        case (phase)
            PH_IDLE: begin
                if (kind == EV_MATCH) begin
                    drop_frame();
                    phase = PH_RECV;
                end
            end
            PH_RECV: begin
                if (kind != EV_DATA) begin
                    phase = PH_IDLE;
                    owe_error(ERR_MISSING_DATA);
                end else if (taken == 2'd0) begin
                    held_cmd = data;
                    taken    = 2'd1;
                end else if (taken == 2'd1) begin
                    held_spd = data;
                    taken    = 2'd2;
                end else begin
                    held_chk = data;
                    taken    = 2'd3;
                    phase    = PH_EOF;
                end
            end
            PH_EOF: begin
                phase = PH_IDLE;
                cmd   = held_cmd;
                if (kind != EV_EOF) begin
                    owe_error(ERR_MISSING_EOF);
                end else if (cmd == cd_fwd || cmd == cd_rev || cmd == cd_coast
                             || cmd == cd_brake) begin
                    if (held_spd == 8'd0 || held_spd >= SPEED_LIMIT
                        || held_chk != (cmd ^ held_spd)) begin
                        owe_error(ERR_BAD_DATA);
                    end else begin
                        // first matching code wins when codes overlap
                        if (cmd == cd_fwd) begin
                            bridge_mode  = MODE_FWD;
                            bridge_speed = held_spd;
                        end else if (cmd == cd_rev) begin
                            bridge_mode  = MODE_REV;
                            bridge_speed = held_spd;
                        end else if (cmd == cd_coast) begin
                            bridge_mode  = MODE_COAST;
                            bridge_speed = 8'd1;
                        end else begin
                            bridge_mode  = MODE_BRAKE;
                            bridge_speed = held_spd;
                        end
                        owe_status();
                    end
                end else if (cmd == cd_status) begin
                    owe_status();
                end else begin
                    owe_error(ERR_BAD_DATA);
                end
            end
            default: begin
                phase = PH_IDLE;
                drop_frame();
            end
        endcase
    endfunction

    function automatic void note_failure(input string what, input t_reply_word want,
                                         input t_reply_word got);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display({"%0t: %s: expected byte %02h last %0d mode %0d duty %0d, ",
                      "got byte %02h last %0d mode %0d duty %0d"},
                     $time, what, want.reply_byte, want.reply_last, want.drive_mode,
                     want.drive_duty, got.reply_byte, got.reply_last, got.drive_mode,
                     got.drive_duty);
    endfunction

    always @(posedge i_clk) begin
        t_reply_word got;
        t_reply_word want;
        if (!i_rst_n) begin
            node_addr    = 8'd0;
            cd_fwd       = 8'd1;
            cd_rev       = 8'd2;
            cd_coast     = 8'd3;
            cd_brake     = 8'd4;
            cd_status    = 8'd5;
            phase        = PH_IDLE;
            bridge_mode  = MODE_COAST;
            bridge_speed = 8'd1;
            drop_frame();
            owed_replies.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NODE_ADDRESS: node_addr = i_cfg_data;
                    CFG_CODE_FORWARD: cd_fwd    = i_cfg_data;
                    CFG_CODE_REVERSE: cd_rev    = i_cfg_data;
                    CFG_CODE_COAST:   cd_coast  = i_cfg_data;
                    CFG_CODE_BRAKE:   cd_brake  = i_cfg_data;
                    CFG_CODE_STATUS:  cd_status = i_cfg_data;
                    default: ;
                endcase
            end
            // replies leaving now belong to earlier events, so pop before decoding
            if (i_reply_valid && i_reply_ready) begin
                got.reply_byte = i_reply_byte;
                got.reply_last = i_reply_last;
                got.drive_mode = i_drive_mode;
                got.drive_duty = i_drive_duty;
                if (owed_replies.size() == 0) begin
                    note_failure("unexpected reply word", '0, got);
                end else begin
                    want = owed_replies.pop_front();
                    if (got !== want)
                        note_failure("reply word mismatch", want, got);
                end
            end
            if (i_evt_valid && i_evt_ready)
                decode_event(i_evt_kind, i_evt_byte);
        end
        o_pending = owed_replies.size();
    end

endmodule

### dv/tb_motor_command_frame_receiver.sv
`timescale 1ns / 100ps
// tb_motor_command_frame_receiver: stimulus, flow control and verdict for the frame receiver
// depends on mcfr_pkg, both channel interfaces, the block and mcfr_reply_checker

module tb_motor_command_frame_receiver;
    import mcfr_pkg::*;

    // kinds the block does not define, handled like ignore
    localparam logic [2:0] EV_SPARE_A = 3'd6;
    localparam logic [2:0] EV_SPARE_B = 3'd7;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    // replies are at most four words, plus margin for the decode cycle
    localparam int SETTLE_CYCLES = 10;
    localparam int PHASE_WORDS   = 88;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [2:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    mcfr_evt_if   evt_ch ();
    mcfr_reply_if reply_ch ();

    int fail_count;
    int pending;

    // flow control knobs, in percent
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;

    // long receiver hold-off, requested here and timed in the ready process
    bit hold_wanted = 1'b0;
    bit hold_done   = 1'b0;
    int hold_left   = 0;

    // words sent that the block acts on (idle noise not counted)
    int words_sent = 0;
    int cycle_count = 0;

    // what the registers hold now, used to aim commands at real codes
    logic [7:0] reg_val [6] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5};

    motor_command_frame_receiver i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_evt       (evt_ch),
        .o_reply     (reply_ch)
    );

    mcfr_reply_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_evt_valid   (evt_ch.valid),
        .i_evt_ready   (evt_ch.ready),
        .i_evt_kind    (evt_ch.event_kind),
        .i_evt_byte    (evt_ch.rx_byte),
        .i_reply_valid (reply_ch.valid),
        .i_reply_ready (reply_ch.ready),
        .i_reply_byte  (reply_ch.reply_byte),
        .i_reply_last  (reply_ch.reply_last),
        .i_drive_mode  (reply_ch.drive_mode),
        .i_drive_duty  (reply_ch.drive_duty),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // reply side: random stalls, plus one long hold-off so the block backs up
    // into its event input while the sender keeps offering
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            reply_ch.ready <= 1'b0;
            hold_left--;
        end else if (hold_wanted && !hold_done) begin
            reply_ch.ready <= 1'b0;
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end else begin
            reply_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // offer one event word; valid gets exactly one assignment per falling edge
    task automatic offer_event(input logic [2:0] kind, input logic [7:0] data,
                               input bit counted);
        bit placed;
        placed = 1'b0;
        while (!placed) begin
            @(negedge i_clk);
            if ($urandom_range(99) < src_idle_pct) begin
                evt_ch.valid <= 1'b0;
            end else begin
                evt_ch.valid      <= 1'b1;
                evt_ch.event_kind <= kind;
                evt_ch.rx_byte    <= data;
                placed = 1'b1;
            end
        end
        do @(posedge i_clk); while (!evt_ch.ready);
        if (counted)
            words_sent++;
    endtask

    // full frame: address match, command, speed, check, then a closing event
    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] spd,
                              input logic [7:0] chk, input logic [2:0] closer);
        offer_event(EV_MATCH, 8'($urandom_range(255)), 1'b1);
        offer_event(EV_DATA, cmd, 1'b1);
        offer_event(EV_DATA, spd, 1'b1);
        offer_event(EV_DATA, chk, 1'b1);
        offer_event(closer, 8'($urandom_range(255)), 1'b1);
    endtask

    // stop offering, wait for every owed reply word, then let the block go quiet
    task automatic drain();
        @(negedge i_clk);
        evt_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // back-to-back writes of all six registers, only ever called while drained
    task automatic program_regs(input logic [7:0] addr, input logic [7:0] fwd,
                                input logic [7:0] rev, input logic [7:0] coast,
                                input logic [7:0] brake, input logic [7:0] status);
        logic [7:0] vals [6];
        vals = '{addr, fwd, rev, coast, brake, status};
        for (int r = CFG_NODE_ADDRESS; r <= CFG_CODE_STATUS; r++) begin
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= r[2:0];
            i_cfg_data  <= vals[r[2:0]];
            reg_val[r[2:0]] = vals[r[2:0]];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly well-formed frames with random content; the rest idle noise,
    // truncated frames and frames without a proper end of frame
    task automatic random_frame();
        logic [2:0] kind;
        logic [7:0] cmd;
        logic [7:0] spd;
        logic [7:0] chk;
        int         cut;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            // noise while idle; a match would open a frame, so never use one here
            do kind = 3'($urandom_range(7)); while (kind == EV_MATCH);
            offer_event(kind, 8'($urandom_range(255)), 1'b0);
            return;
        end
        if ($urandom_range(99) < 70)
            cmd = reg_val[3'($urandom_range(CFG_CODE_STATUS, CFG_CODE_FORWARD))];
        else
            cmd = 8'($urandom_range(255));
        case ($urandom_range(7))
            0:       spd = 8'd0;
            1:       spd = SPEED_LIMIT;
            2:       spd = 8'($urandom_range(255));
            default: spd = 8'($urandom_range(SPEED_LIMIT - 1, 1));
        endcase
        chk = ($urandom_range(99) < 85) ? (cmd ^ spd) : 8'($urandom_range(255));
        // cut: 0 keeps all three bytes, else the frame breaks after cut-1 bytes
        cut = ($urandom_range(99) < 10) ? $urandom_range(3, 1) : 0;
        offer_event(EV_MATCH, 8'($urandom_range(255)), 1'b1);
        for (int b = 0; b < 3; b++) begin
            if (cut == b + 1) begin
                do kind = 3'($urandom_range(7)); while (kind == EV_DATA);
                offer_event(kind, 8'($urandom_range(255)), 1'b1);
                return;
            end
            offer_event(EV_DATA, (b == 0) ? cmd : (b == 1) ? spd : chk, 1'b1);
        end
        if ($urandom_range(99) < 88) begin
            offer_event(EV_EOF, 8'($urandom_range(255)), 1'b1);
        end else begin
            do kind = 3'($urandom_range(7)); while (kind == EV_EOF);
            offer_event(kind, 8'($urandom_range(255)), 1'b1);
        end
    endtask

    task automatic random_phase(input int idle_pct, input int stall_pct);
        int target;
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        target = words_sent + PHASE_WORDS;
        while (words_sent < target)
            random_frame();
        drain();
    endtask

    initial begin
        // known values on every input from time zero
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_index         = CFG_NODE_ADDRESS;
        i_cfg_data          = 8'd0;
        evt_ch.valid        = 1'b0;
        evt_ch.event_kind   = EV_IGNORE;
        evt_ch.rx_byte      = 8'd0;
        reply_ch.ready      = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset register values
        // idle: data and an undefined kind are both dropped
        offer_event(EV_DATA, 8'hFF, 1'b0);
        offer_event(EV_SPARE_B, 8'h00, 1'b0);
        // each command once, forward and reverse at the edges of the speed range
        send_frame(8'd1, 8'd99, 8'd1 ^ 8'd99, EV_EOF);
        send_frame(8'd2, 8'd1, 8'd2 ^ 8'd1, EV_EOF);
        send_frame(8'd4, 8'd50, 8'd4 ^ 8'd50, EV_EOF);
        send_frame(8'd3, 8'd7, 8'd3 ^ 8'd7, EV_EOF);
        // status query answers despite zero speed and a wrong check byte
        send_frame(8'd5, 8'd0, 8'hFF, EV_EOF);
        // speed at the limit is bad data
        send_frame(8'd1, SPEED_LIMIT, 8'd1 ^ SPEED_LIMIT, EV_EOF);
        // unknown command is bad data, motor untouched
        send_frame(8'hFF, 8'd10, 8'hFF ^ 8'd10, EV_EOF);
        // another data byte where end of frame belongs
        send_frame(8'd1, 8'd20, 8'd1 ^ 8'd20, EV_DATA);
        // frame cut short by an error event after one byte
        offer_event(EV_MATCH, 8'h00, 1'b1);
        offer_event(EV_DATA, 8'd1, 1'b1);
        offer_event(EV_ERROR, 8'h00, 1'b1);
        drain();

        // extremes in every register; long reply hold-off with no idling
        program_regs(8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01);
        hold_wanted = 1'b1;
        random_phase(0, 0);

        // overlapping codes: forward beats reverse and status, coast beats brake
        program_regs(8'h00, 8'h3C, 8'h3C, 8'hC3, 8'hC3, 8'h3C);
        random_phase(86, 0);

        program_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 8'($urandom_range(255)));
        random_phase(0, 86);

        program_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 8'($urandom_range(255)));
        random_phase(34, 34);

        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
design/mcfr_pkg.sv
design/mcfr_evt_if.sv
design/mcfr_reply_if.sv
design/motor_command_frame_receiver.sv
dv/mcfr_reply_checker.sv
dv/tb_motor_command_frame_receiver.sv
